// ----- src/rhc_pkg.sv -----
// Shared types, constants and the divider step function for the RGB to HSV converter.
package rhc_pkg;

    localparam int COMP_BITS  = 8;
    localparam int SAT_BITS   = 16;
    localparam int HUE_BITS   = 16;
    // 6 * delta needs three bits above a component
    localparam int HUE_REM_W  = COMP_BITS + 3;
    localparam int DIV_STAGES = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;

    typedef enum logic [2:0] {
        SECTOR_RED   = 3'b001,
        SECTOR_GREEN = 3'b010,
        SECTOR_BLUE  = 3'b100
    } sector_t;

    typedef struct packed {
        logic [COMP_BITS-1:0] red;
        logic [COMP_BITS-1:0] green;
        logic [COMP_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]  hue;
        logic [SAT_BITS-1:0]  saturation;
        logic [COMP_BITS-1:0] value;
    } hsv_t;

    // Working state of both fractional divisions as it moves down the pipe
    typedef struct packed {
        logic [HUE_REM_W-1:0] hue_rem;
        logic [HUE_REM_W-1:0] hue_den;
        logic [HUE_BITS-1:0]  hue_q;
        logic [COMP_BITS-1:0] sat_rem;
        logic [COMP_BITS-1:0] sat_den;
        logic [SAT_BITS-1:0]  sat_q;
        logic [COMP_BITS-1:0] value;
        logic                 hue_zero;
        logic                 sat_zero;
        logic                 sat_full;
    } div_t;

    // One restoring step per division; numerator is below divisor unless flagged.
    function automatic div_t div_step(input div_t d, input int idx);
        div_t                 r;
        logic [HUE_REM_W:0]   ht;
        logic [COMP_BITS:0]   st;
        r  = d;
        ht = {d.hue_rem, 1'b0};
        st = {d.sat_rem, 1'b0};
        if (idx < HUE_BITS)
        begin
            if (ht >= {1'b0, d.hue_den})
            begin
                r.hue_rem = HUE_REM_W'(ht - {1'b0, d.hue_den});
                r.hue_q   = {d.hue_q[HUE_BITS-2:0], 1'b1};
            end
            else
            begin
                r.hue_rem = ht[HUE_REM_W-1:0];
                r.hue_q   = {d.hue_q[HUE_BITS-2:0], 1'b0};
            end
        end
        if (idx < SAT_BITS)
        begin
            if (st >= {1'b0, d.sat_den})
            begin
                r.sat_rem = COMP_BITS'(st - {1'b0, d.sat_den});
                r.sat_q   = {d.sat_q[SAT_BITS-2:0], 1'b1};
            end
            else
            begin
                r.sat_rem = st[COMP_BITS-1:0];
                r.sat_q   = {d.sat_q[SAT_BITS-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ----- src/rhc_front.sv -----
// Front end: max/min and sector pick, then delta, hue numerator and divisors.
module rhc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rhc_pkg::pixel_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rhc_pkg::div_t   out_data
);

    localparam int RW  = rhc_pkg::HUE_REM_W;
    localparam int CW  = rhc_pkg::COMP_BITS;
    localparam int N_W = RW + 1;

    // stage A
    logic                    a_valid_reg;
    rhc_pkg::pixel_t         a_pix_reg;
    logic [CW-1:0]           a_max_reg;
    logic [CW-1:0]           a_min_reg;
    rhc_pkg::sector_t        a_sector_reg;
    logic                    a_ready;

    logic [CW-1:0]           hi;
    logic [CW-1:0]           lo;
    rhc_pkg::sector_t        sector;

    // stage B
    logic                    b_valid_reg;
    rhc_pkg::div_t           b_data_reg;
    logic                    b_ready;

    logic [CW-1:0]           delta;
    logic [RW-1:0]           den;
    logic [RW-1:0]           offset;
    logic signed [N_W-1:0]   diff;
    logic signed [N_W-1:0]   n;
    rhc_pkg::div_t           b_next;

    always_comb
    begin
        hi = in_data.red;
        lo = in_data.red;
        if (in_data.green > hi) hi = in_data.green;
        if (in_data.blue > hi)  hi = in_data.blue;
        if (in_data.green < lo) lo = in_data.green;
        if (in_data.blue < lo)  lo = in_data.blue;
        if (hi == in_data.red)
            sector = rhc_pkg::SECTOR_RED;
        else if (hi == in_data.green)
            sector = rhc_pkg::SECTOR_GREEN;
        else
            sector = rhc_pkg::SECTOR_BLUE;
    end

    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_ready)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_pix_reg    <= in_data;
            a_max_reg    <= hi;
            a_min_reg    <= lo;
            a_sector_reg <= sector;
        end
    end

    always_comb
    begin
        delta = a_max_reg - a_min_reg;
        den   = RW'({delta, 2'b00}) + RW'({delta, 1'b0});
        case (a_sector_reg)
            rhc_pkg::SECTOR_RED:
            begin
                offset = '0;
                diff   = $signed({{(N_W-CW){1'b0}}, a_pix_reg.green})
                       - $signed({{(N_W-CW){1'b0}}, a_pix_reg.blue});
            end
            rhc_pkg::SECTOR_GREEN:
            begin
                offset = RW'({delta, 1'b0});
                diff   = $signed({{(N_W-CW){1'b0}}, a_pix_reg.blue})
                       - $signed({{(N_W-CW){1'b0}}, a_pix_reg.red});
            end
            rhc_pkg::SECTOR_BLUE:
            begin
                offset = RW'({delta, 2'b00});
                diff   = $signed({{(N_W-CW){1'b0}}, a_pix_reg.red})
                       - $signed({{(N_W-CW){1'b0}}, a_pix_reg.green});
            end
            default:
            begin
                offset = '0;
                diff   = '0;
            end
        endcase
        n = $signed({1'b0, offset}) + diff;
        // negative hue wraps by one turn
        if (n < 0)
            n = n + $signed({1'b0, den});

        b_next          = '0;
        b_next.hue_rem  = n[RW-1:0];
        b_next.hue_den  = den;
        b_next.sat_rem  = delta;
        b_next.sat_den  = a_max_reg;
        b_next.value    = a_max_reg;
        b_next.hue_zero = (delta == '0);
        b_next.sat_zero = (a_max_reg == '0);
        b_next.sat_full = (a_min_reg == '0) && (a_max_reg != '0);
    end

    assign b_ready = !b_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
            b_data_reg <= b_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

// ----- src/rhc_div_pipe.sv -----
// Pipelined restoring divider: one hue and one saturation quotient bit per stage.
module rhc_div_pipe (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rhc_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rhc_pkg::div_t out_data
);

    localparam int STAGES = rhc_pkg::DIV_STAGES;

    logic [STAGES-1:0] valid_reg;
    rhc_pkg::div_t     data_reg [STAGES];
    logic [STAGES:0]   stage_ready;

    assign stage_ready[STAGES] = out_ready;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic          src_valid;
        rhc_pkg::div_t src;
        rhc_pkg::div_t step;

        if (i == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src       = in_data;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[i-1];
            assign src       = data_reg[i-1];
        end

        assign stage_ready[i] = !valid_reg[i] || stage_ready[i+1];

        always_comb
        begin
            step = rhc_pkg::div_step(src, i);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (stage_ready[i])
                valid_reg[i] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[i] && src_valid)
                data_reg[i] <= step;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_data  = data_reg[STAGES-1];

    // remainders stay below their divisors unless the flags override the result
    a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hue_zero |-> out_data.hue_rem < out_data.hue_den)
        else $error("hue remainder not below divisor");

    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.sat_zero && !out_data.sat_full
        |-> out_data.sat_rem < out_data.sat_den)
        else $error("saturation remainder not below divisor");

    a_black_grey: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sat_zero |-> out_data.hue_zero)
        else $error("black pixel not flagged grey");

endmodule

// ----- src/rgb_to_hsv_converter.sv -----
// Top level of the pipelined RGB to HSV converter.
// Accepts one pixel per clock and returns one HSV result per pixel, in order.
// The pipeline has two front stages for max/min, sector and divisor setup, one
// stage per quotient bit of the hue and saturation long division (both run side
// by side in the same stages), and an output register. Every stage is elastic,
// so backpressure stalls only the stages that hold data and bubbles are
// squeezed out.
module rgb_to_hsv_converter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pixel_valid,
    output logic            pixel_ready,
    input  rhc_pkg::pixel_t pixel,
    output logic            hsv_valid,
    input  logic            hsv_ready,
    output rhc_pkg::hsv_t   hsv
);

    logic          front_valid;
    logic          front_ready;
    rhc_pkg::div_t front_data;

    logic          div_valid;
    logic          div_ready;
    rhc_pkg::div_t div_data;

    logic          out_valid_reg;
    rhc_pkg::hsv_t out_reg;
    rhc_pkg::hsv_t out_next;

    rhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .in_ready  (pixel_ready),
        .in_data   (pixel),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    rhc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    always_comb
    begin
        out_next.value = div_data.value;
        out_next.hue   = div_data.hue_zero ? '0 : div_data.hue_q;
        if (div_data.sat_zero)
            out_next.saturation = '0;
        else if (div_data.sat_full)
            out_next.saturation = '1;   // 1.0 clamps to the largest code
        else
            out_next.saturation = div_data.sat_q;
    end

    assign div_ready = !out_valid_reg || hsv_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (div_ready)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (div_ready && div_valid)
            out_reg <= out_next;
    end

    assign hsv_valid = out_valid_reg;
    assign hsv       = out_reg;

    a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hsv.value == '0 |-> hsv.saturation == '0)
        else $error("black pixel with nonzero saturation");

    a_black_hue: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hsv.value == '0 |-> hsv.hue == '0)
        else $error("black pixel with nonzero hue");

    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hsv.saturation == '0 |-> hsv.hue == '0)
        else $error("unsaturated pixel with nonzero hue");

endmodule
